// ===== rtl/rsh_pkg.sv =====
`default_nettype none

package rsh_pkg;

  localparam int HASH_W = 30;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 12;
  localparam int SLEN_W = 13;

  localparam logic [HASH_W-1:0] HMOD        = 30'd1000000007;
  localparam logic [HASH_W-1:0] HBASE       = 30'd31;
  localparam logic [HASH_W-1:0] HBASE_RECIP = 30'd129032259;
  localparam logic [CHAR_W-1:0] CHAR_OFFSET = 8'd96;

  // Barrett constant floor(2^60 / HMOD); fits in 31 bits.
  localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'(HMOD));

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } command_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic              valid;
    logic [HASH_W-1:0] a;
    logic [HASH_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              valid;
    logic [HASH_W-1:0] res;
  } mul_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/rsh_ram.sv =====
`default_nettype none

module rsh_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/rsh_mulmod.sv =====
`default_nettype none

module rsh_mulmod
  import rsh_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire mul_req_t req_i,
  output mul_rsp_t      rsp_o
);

  // Four stages: product, Barrett quotient, quotient times modulus, correction.
  logic        v1_q, v2_q, v3_q, v4_q;
  logic [59:0] prod_q;
  logic [30:0] quo_q;
  logic [31:0] low2_q, low3_q, qp_q;
  logic [HASH_W-1:0] res_q;

  logic [59:0] prod_d;
  logic [61:0] q2_full;
  logic [31:0] qp_d;
  logic [31:0] rem;
  logic [31:0] two_mod;
  logic [HASH_W-1:0] res_d;

  assign prod_d  = 60'(req_i.a) * 60'(req_i.b);
  assign q2_full = 62'(prod_q[59:29]) * 62'(BARRETT_MU);
  assign qp_d    = 32'(quo_q) * 32'(HMOD);
  assign rem     = low3_q - qp_q;
  assign two_mod = {1'b0, HMOD, 1'b0};

  // The Barrett remainder stays below three times the modulus.
  always_comb begin
    if (rem >= two_mod) begin
      res_d = HASH_W'(rem - two_mod);
    end else if (rem >= 32'(HMOD)) begin
      res_d = HASH_W'(rem - 32'(HMOD));
    end else begin
      res_d = HASH_W'(rem);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= req_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    quo_q  <= q2_full[61:31];
    low2_q <= prod_q[31:0];
    qp_q   <= qp_d;
    low3_q <= low2_q;
    res_q  <= res_d;
  end

  assign rsp_o.valid = v4_q;
  assign rsp_o.res   = res_q;

endmodule

`default_nettype wire

// ===== rtl/rolling_substring_hash_top.sv =====
`default_nettype none

// Polynomial rolling hash of a growing string, modulo 1000000007 with base 31.
// A request is taken on a clock edge where start is high and busy is low; it
// carries command_i (clear, append, query), char_code_i for an append and
// first_index_i/last_index_i for a query. Each request gives exactly one
// result, shown for one cycle with done_o high, together with hash_value_o,
// status_o and string_length_o. The receiver cannot stall the result.
// Clear, an unused command, a full store and a bad range are answered without
// leaving idle, so the next request may follow at once. Appends and queries use
// the four-stage modular multiplier (three products per append) and the single
// read port of the prefix hash memory, which is read twice per query. busy stays
// high while a request is in work. Reset clears the length and sets the running
// power and inverse to one; the memories are not cleared, and a query only reads
// entries below the length.

module rolling_substring_hash_top
  import rsh_pkg::*;
#(
  parameter int MAX_LENGTH = 4096
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        command_i,
  input  wire logic [CHAR_W-1:0] char_code_i,
  input  wire logic [IDX_W-1:0]  first_index_i,
  input  wire logic [IDX_W-1:0]  last_index_i,
  output logic                   done_o,
  output logic [HASH_W-1:0]      hash_value_o,
  output logic [1:0]             status_o,
  output logic [SLEN_W-1:0]      string_length_o
);

  localparam int AW    = $clog2(MAX_LENGTH);
  localparam int LEN_W = $clog2(MAX_LENGTH + 1);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_APP_V    = 10'b00_0000_0010,
    S_APP_P    = 10'b00_0000_0100,
    S_APP_I    = 10'b00_0000_1000,
    S_APP_WAIT = 10'b00_0001_0000,
    S_Q_RD1    = 10'b00_0010_0000,
    S_Q_RD2    = 10'b00_0100_0000,
    S_Q_SUB    = 10'b00_1000_0000,
    S_Q_MUL    = 10'b01_0000_0000,
    S_Q_WAIT   = 10'b10_0000_0000
  } state_e;

  function automatic logic [HASH_W-1:0] mod_add(input logic [HASH_W-1:0] a,
                                                input logic [HASH_W-1:0] b);
    logic [HASH_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, HMOD}) begin
      s = s - {1'b0, HMOD};
    end
    return s[HASH_W-1:0];
  endfunction

  function automatic logic [HASH_W-1:0] mod_sub(input logic [HASH_W-1:0] a,
                                                input logic [HASH_W-1:0] b);
    logic [HASH_W-1:0] r;
    r = a - b;
    if (a < b) begin
      r = r + HMOD;
    end
    return r;
  endfunction

  state_e            state_q, state_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [HASH_W-1:0] power_q, power_d;
  logic [HASH_W-1:0] inv_q, inv_d;
  logic [HASH_W-1:0] last_hash_q, last_hash_d;
  logic [HASH_W-1:0] hash_q, hash_d;
  logic [HASH_W-1:0] ip_q, ip_d;
  logic [HASH_W-1:0] diff_q, diff_d;
  logic [HASH_W-1:0] val_q, val_d;
  logic [IDX_W-1:0]  first_q, first_d;
  logic [IDX_W-1:0]  last_q, last_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [HASH_W-1:0] res_hash_q, res_hash_d;
  status_e           res_status_q, res_status_d;

  logic              accept;
  logic              store_full;
  logic              bad_range;
  logic [HASH_W-1:0] char_val;
  logic              mem_we;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     pre_raddr;
  logic [AW-1:0]     inv_raddr;
  logic [HASH_W-1:0] pre_rdata;
  logic [HASH_W-1:0] inv_rdata;
  mul_req_t          mul_req;
  mul_rsp_t          mul_rsp;

  assign busy       = (state_q != S_IDLE);
  assign accept     = start && !busy;
  assign store_full = (len_q == LEN_W'(MAX_LENGTH));
  assign bad_range  = (first_index_i > last_index_i) ||
                      (32'(last_index_i) >= 32'(len_q)) ||
                      (32'(last_index_i) >= 32'(MAX_LENGTH));

  // Bytes below the offset wrap around the modulus.
  assign char_val = (char_code_i >= CHAR_OFFSET) ? HASH_W'(char_code_i - CHAR_OFFSET)
                                                 : HMOD - HASH_W'(CHAR_OFFSET - char_code_i);

  assign waddr     = AW'(len_q);
  assign inv_raddr = AW'(first_q);

  always_comb begin
    state_d      = state_q;
    len_d        = len_q;
    power_d      = power_q;
    inv_d        = inv_q;
    last_hash_d  = last_hash_q;
    hash_d       = hash_q;
    ip_d         = ip_q;
    diff_d       = diff_q;
    val_d        = val_q;
    first_d      = first_q;
    last_d       = last_q;
    cnt_d        = cnt_q;
    done_d       = 1'b0;
    res_hash_d   = res_hash_q;
    res_status_d = res_status_q;
    mem_we       = 1'b0;
    pre_raddr    = AW'(last_q);
    mul_req      = '{valid: 1'b0, a: val_q, b: power_q};

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          first_d = first_index_i;
          last_d  = last_index_i;
          case (command_i)
            CMD_CLEAR: begin
              len_d        = '0;
              power_d      = HASH_W'(1);
              inv_d        = HASH_W'(1);
              last_hash_d  = '0;
              done_d       = 1'b1;
              res_hash_d   = '0;
              res_status_d = ST_OK;
            end
            CMD_APPEND: begin
              if (store_full) begin
                done_d       = 1'b1;
                res_hash_d   = '0;
                res_status_d = ST_FULL;
              end else begin
                val_d   = char_val;
                cnt_d   = '0;
                state_d = S_APP_V;
              end
            end
            CMD_QUERY: begin
              if (bad_range) begin
                done_d       = 1'b1;
                res_hash_d   = '0;
                res_status_d = ST_RANGE;
              end else begin
                cnt_d   = '0;
                state_d = S_Q_RD1;
              end
            end
            default: begin
              done_d       = 1'b1;
              res_hash_d   = '0;
              res_status_d = ST_OK;
            end
          endcase
        end
      end
      S_APP_V: begin
        mul_req = '{valid: 1'b1, a: val_q, b: power_q};
        state_d = S_APP_P;
      end
      S_APP_P: begin
        mul_req = '{valid: 1'b1, a: power_q, b: HBASE};
        state_d = S_APP_I;
      end
      S_APP_I: begin
        mul_req = '{valid: 1'b1, a: inv_q, b: HBASE_RECIP};
        state_d = S_APP_WAIT;
      end
      S_APP_WAIT: begin
        // Products return in issue order: term, next power, next inverse.
        if (mul_rsp.valid) begin
          cnt_d = cnt_q + 2'd1;
          case (cnt_q)
            2'd0: hash_d = mod_add(last_hash_q, mul_rsp.res);
            2'd1: power_d = mul_rsp.res;
            2'd2: begin
              inv_d        = mul_rsp.res;
              mem_we       = 1'b1;
              len_d        = len_q + 1'b1;
              last_hash_d  = hash_q;
              done_d       = 1'b1;
              res_hash_d   = hash_q;
              res_status_d = ST_OK;
              state_d      = S_IDLE;
            end
            default: cnt_d = cnt_q;
          endcase
        end
      end
      S_Q_RD1: begin
        pre_raddr = AW'(last_q);
        state_d   = S_Q_RD2;
      end
      S_Q_RD2: begin
        pre_raddr = AW'(first_q - 1'b1);
        if (first_q == '0) begin
          done_d       = 1'b1;
          res_hash_d   = pre_rdata;
          res_status_d = ST_OK;
          state_d      = S_IDLE;
        end else begin
          hash_d  = pre_rdata;
          ip_d    = inv_rdata;
          state_d = S_Q_SUB;
        end
      end
      S_Q_SUB: begin
        diff_d  = mod_sub(hash_q, pre_rdata);
        state_d = S_Q_MUL;
      end
      S_Q_MUL: begin
        mul_req = '{valid: 1'b1, a: diff_q, b: ip_q};
        state_d = S_Q_WAIT;
      end
      S_Q_WAIT: begin
        if (mul_rsp.valid) begin
          done_d       = 1'b1;
          res_hash_d   = mul_rsp.res;
          res_status_d = ST_OK;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      power_q     <= HASH_W'(1);
      inv_q       <= HASH_W'(1);
      last_hash_q <= '0;
      cnt_q       <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      power_q     <= power_d;
      inv_q       <= inv_d;
      last_hash_q <= last_hash_d;
      cnt_q       <= cnt_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q       <= hash_d;
    ip_q         <= ip_d;
    diff_q       <= diff_d;
    val_q        <= val_d;
    first_q      <= first_d;
    last_q       <= last_d;
    res_hash_q   <= res_hash_d;
    res_status_q <= res_status_d;
  end

  rsh_ram #(
    .WIDTH(HASH_W),
    .DEPTH(MAX_LENGTH)
  ) u_prefix_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(waddr),
    .wdata_i(hash_q),
    .raddr_i(pre_raddr),
    .rdata_o(pre_rdata)
  );

  // The inverse written is the one that held before this append.
  rsh_ram #(
    .WIDTH(HASH_W),
    .DEPTH(MAX_LENGTH)
  ) u_inverse_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(waddr),
    .wdata_i(inv_q),
    .raddr_i(inv_raddr),
    .rdata_o(inv_rdata)
  );

  rsh_mulmod u_mulmod (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mul_req),
    .rsp_o (mul_rsp)
  );

  assign done_o          = done_q;
  assign hash_value_o    = res_hash_q;
  assign status_o        = res_status_q;
  assign string_length_o = SLEN_W'(len_q);

`ifndef SYNTH
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == S_IDLE))
    else $error("result strobe while a request is still in work");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(MAX_LENGTH))
    else $error("stored length beyond capacity");

  a_mul_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.valid |-> (state_q == S_APP_WAIT || state_q == S_Q_WAIT))
    else $error("multiplier result outside a wait state");

  a_append_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && $past(state_q == S_APP_WAIT)) |-> (len_q == LEN_W'($past(len_q) + 1'b1)))
    else $error("append did not advance the length by one");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_rolling_substring_hash_top.sv =====
`default_nettype none

module tb_rolling_substring_hash_top;
  import rsh_pkg::*;

  localparam longint unsigned MODULUS    = 64'd1000000007;
  localparam longint unsigned BASE       = 64'd31;
  localparam longint unsigned BASE_RECIP = 64'd129032259;
  localparam longint unsigned CHAR_BIAS  = 64'd96;
  localparam int MAX_LEN      = 4096;
  localparam int LONG_LEN     = 500;
  localparam int MIX_ITEMS    = 700;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 50;

  typedef struct {
    logic [HASH_W-1:0] hash;
    status_e           status;
    logic [SLEN_W-1:0] length;
  } hash_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        command_i = CMD_CLEAR;
  logic [CHAR_W-1:0] char_code_i = '0;
  logic [IDX_W-1:0]  first_index_i = '0;
  logic [IDX_W-1:0]  last_index_i = '0;
  logic              done_o;
  logic [HASH_W-1:0] hash_value_o;
  logic [1:0]        status_o;
  logic [SLEN_W-1:0] string_length_o;

  // Predicted state of the string.
  longint unsigned hash_prefix [MAX_LEN];
  longint unsigned inv_pow [MAX_LEN];
  int              str_len = 0;
  longint unsigned pow_now = 1;
  longint unsigned inv_now = 1;

  hash_result_t pending_results [$];
  int           error_count = 0;
  int           idle_cycles = 0;
  int           max_gap = 14;

  rolling_substring_hash_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .char_code_i    (char_code_i),
    .first_index_i  (first_index_i),
    .last_index_i   (last_index_i),
    .done_o         (done_o),
    .hash_value_o   (hash_value_o),
    .status_o       (status_o),
    .string_length_o(string_length_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint unsigned mulmod(longint unsigned a, longint unsigned b);
    return (a * b) % MODULUS;
  endfunction

  // Updates the predicted string and returns the result the request should give.
  function automatic hash_result_t apply_request(command_e cmd, logic [CHAR_W-1:0] code,
                                                 logic [IDX_W-1:0] first,
                                                 logic [IDX_W-1:0] last);
    hash_result_t    r;
    longint unsigned v;
    longint unsigned prev;
    longint unsigned diff;
    r.hash = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_CLEAR: begin
        str_len = 0;
        pow_now = 1;
        inv_now = 1;
      end
      CMD_APPEND: begin
        if (str_len >= MAX_LEN) begin
          r.status = ST_FULL;
        end else begin
          v = (code >= CHAR_BIAS) ? code - CHAR_BIAS : MODULUS - (CHAR_BIAS - code);
          prev = (str_len == 0) ? 0 : hash_prefix[str_len-1];
          hash_prefix[str_len] = (prev + mulmod(v, pow_now)) % MODULUS;
          inv_pow[str_len] = inv_now;
          r.hash = HASH_W'(hash_prefix[str_len]);
          str_len++;
          pow_now = mulmod(pow_now, BASE);
          inv_now = mulmod(inv_now, BASE_RECIP);
        end
      end
      CMD_QUERY: begin
        if (first > last || int'(last) >= str_len) begin
          r.status = ST_RANGE;
        end else if (first == 0) begin
          r.hash = HASH_W'(hash_prefix[last]);
        end else begin
          diff = (hash_prefix[last] + MODULUS - hash_prefix[first-1]) % MODULUS;
          r.hash = HASH_W'(mulmod(diff, inv_pow[first]));
        end
      end
      default: begin
      end
    endcase
    r.length = SLEN_W'(str_len);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Drives one request, waits for it to be taken, then idles for a random gap.
  // With a gap of zero start stays high for the next request.
  task automatic send_request(input command_e cmd, input logic [CHAR_W-1:0] code,
                              input logic [IDX_W-1:0] first, input logic [IDX_W-1:0] last);
    int gap;
    start <= 1'b1;
    command_i <= cmd;
    char_code_i <= code;
    first_index_i <= first;
    last_index_i <= last;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_results.push_back(apply_request(cmd, code, first, last));
    gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_query(input int first, input int last);
    send_request(CMD_QUERY, CHAR_W'($urandom), IDX_W'(first), IDX_W'(last));
  endtask

  task automatic send_append(input int code);
    send_request(CMD_APPEND, CHAR_W'(code), IDX_W'($urandom), IDX_W'($urandom));
  endtask

  task automatic test_directed();
    send_query(0, 0);
    send_request(CMD_NONE, '0, '0, '0);
    send_append(97);
    send_append(0);
    send_append(255);
    send_append(96);
    send_append(122);
    send_query(0, 0);
    send_query(0, 4);
    send_query(1, 3);
    send_query(4, 4);
    send_query(3, 2);
    send_query(0, 5);
    send_query(4095, 4095);
    send_query(0, 4095);
    send_request(CMD_NONE, '1, '1, '1);
    send_request(CMD_CLEAR, '0, '0, '0);
    send_query(0, 0);
    send_append(98);
    send_query(0, 0);
    send_request(CMD_CLEAR, '1, '1, '1);
    wait_for_results();
  endtask

  // Builds a long string, then queries near its end, past it and at random.
  task automatic test_long_string();
    int hi;
    send_request(CMD_CLEAR, CHAR_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
    for (int n = 0; n < LONG_LEN; n++) begin
      if (n % 128 == 0) max_gap = ($urandom_range(0, 1) == 0) ? 0 : 14;
      send_append(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                               : $urandom_range(97, 122));
    end
    max_gap = 14;
    send_append(97);
    send_append(0);
    send_query(0, str_len - 1);
    send_query(str_len - 1, str_len - 1);
    send_query(str_len - 2, str_len - 1);
    send_query(str_len / 2, str_len - 1);
    send_query(str_len - 1, str_len - 2);
    send_query(str_len, str_len);
    for (int n = 0; n < 40; n++) begin
      hi = $urandom_range(0, str_len - 1);
      if (n % 4 == 0) begin
        send_query($urandom_range(0, MAX_LEN - 1),
                   $urandom_range(0, MAX_LEN - 1));
      end else begin
        send_query($urandom_range(0, hi), hi);
      end
    end
    wait_for_results();
  endtask

  task automatic test_random_mix();
    int pick;
    int hi;
    send_request(CMD_CLEAR, '0, '0, '0);
    for (int n = 0; n < MIX_ITEMS; n++) begin
      if (n % 64 == 0) max_gap = ($urandom_range(0, 2) == 0) ? 0 : 14;
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        send_request(CMD_CLEAR, CHAR_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
      end else if (pick < 5) begin
        send_request(CMD_NONE, CHAR_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
      end else if (pick < 45) begin
        send_append(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(97, 122));
      end else if (pick < 88 && str_len > 0) begin
        hi = $urandom_range(0, str_len - 1);
        send_query(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, hi), hi);
      end else if (pick < 94 && str_len > 1) begin
        // Both ends inside the string but in the wrong order, or one past the end.
        hi = $urandom_range(0, str_len - 2);
        if ($urandom_range(0, 1) == 0) send_query($urandom_range(hi + 1, str_len - 1), hi);
        else send_query($urandom_range(0, str_len - 1), str_len);
      end else begin
        send_query($urandom_range(0, MAX_LEN - 1), $urandom_range(0, MAX_LEN - 1));
      end
    end
    wait_for_results();
  endtask

  always @(posedge clk_i) begin : check_results
    hash_result_t exp_res;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with no request pending: hash %0d status %0d len %0d",
                                  hash_value_o, status_o, string_length_o));
      end else begin
        exp_res = pending_results.pop_front();
        if (hash_value_o !== exp_res.hash || status_o !== exp_res.status ||
            string_length_o !== exp_res.length) begin
          report_mismatch($sformatf(
              "hash %0d/%0d status %0d/%0d len %0d/%0d (got/expected)",
              hash_value_o, exp_res.hash, status_o, exp_res.status,
              string_length_o, exp_res.length));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no request or result for %0d cycles", IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_long_string();
    test_random_mix();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== rolling_substring_hash_top.f =====
rtl/rsh_pkg.sv
rtl/rsh_ram.sv
rtl/rsh_mulmod.sv
rtl/rolling_substring_hash_top.sv
sim/tb_rolling_substring_hash_top.sv
